// ----- sv/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg - shipment record table shared definitions
// Table geometry, opcodes, status codes and the record and result types.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_FIND_FREE = 3'd2;
  localparam logic [2:0] OP_FIND_ID   = 3'd3;
  localparam logic [2:0] OP_SORT      = 3'd4;
  localparam logic [2:0] OP_REFRESH   = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  localparam logic [1:0] ST_NOT_SENT   = 2'd0;
  localparam logic [1:0] ST_IN_TRANSIT = 2'd1;
  localparam logic [1:0] ST_DELIVERED  = 2'd2;

  typedef struct packed {
    logic        used;
    logic [1:0]  ship_state;
    logic [15:0] track;
    logic [15:0] buyer;
    logic [15:0] seller;
    logic [15:0] product;
    logic [31:0] arrival;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  slot;
    logic        descending;
    logic [31:0] now_secs;
    rec_t        rec;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  where_idx;
    rec_t        rec;
    logic        any_used;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    rec_t             data;
  } mem_wr_t;

  function automatic logic slot_in_range(logic [5:0] s);
    logic [IDX_W+6:0] w;
    w = (IDX_W+7)'(s);
    return w < (IDX_W+7)'(TABLE_DEPTH);
  endfunction

  function automatic logic [IDX_W-1:0] slot_to_idx(logic [5:0] s);
    logic [IDX_W+5:0] w;
    w = {IDX_W'(0), s};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [5:0] idx_to_slot(logic [IDX_W-1:0] i);
    logic [IDX_W+5:0] w;
    w = {6'b0, i};
    return w[5:0];
  endfunction

endpackage

// ----- sv/srt_if.sv -----
// ----------------------------------------------------------------------------
// srt_if - shipment record table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [5:0]  slot;
  logic [15:0] track_key;
  logic [15:0] buyer_key;
  logic [15:0] seller_key;
  logic [15:0] product_key;
  logic [31:0] arrival_secs;
  logic [1:0]  ship_state_in;
  logic        used_in;
  logic        descending;
  logic [31:0] now_secs;

  modport source (output valid, opcode, slot, track_key, buyer_key, seller_key,
                  product_key, arrival_secs, ship_state_in, used_in, descending,
                  now_secs, input ready);
  modport sink (input valid, opcode, slot, track_key, buyer_key, seller_key,
                product_key, arrival_secs, ship_state_in, used_in, descending,
                now_secs, output ready);
endinterface

interface srt_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  where_idx;
  logic [15:0] track_out;
  logic [15:0] buyer_out;
  logic [15:0] seller_out;
  logic [15:0] product_out;
  logic [31:0] arrival_out;
  logic [1:0]  ship_state_out;
  logic        used_out;
  logic        any_used;

  modport source (output valid, found, where_idx, track_out, buyer_out, seller_out,
                  product_out, arrival_out, ship_state_out, used_out, any_used,
                  input ready);
  modport sink (input valid, found, where_idx, track_out, buyer_out, seller_out,
                product_out, arrival_out, ship_state_out, used_out, any_used,
                output ready);
endinterface

// ----- sv/shipment_record_table.sv -----
// ----------------------------------------------------------------------------
// shipment_record_table - table of shipment records
// Top level: request/response channels, record memory and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one opcode per transaction (clear, write, find free,
//   find by ID, sort, refresh, read) with its operands; rsp_o returns exactly
//   one result transaction per request, in order.
//   Records live in one RAM word each with a registered read; the
//   occupied mark and status of a never-written entry read as free/not sent
//   through per-entry valid bits, so reset and clear take effect at once.
//   Find and refresh walk the entries through the read port, one entry per
//   cycle, and find stops at the first hit; sort holds one entry and streams
//   its partners, one compare-and-swap per cycle.
//   One request is in flight at a time; req_i.ready is high while the
//   sequencer is idle, also while an earlier result still waits in the
//   output register.
//   After reset all entries read as free and the table reports no occupancy.
//   If rsp_o.ready is low the result holds in the output register and the
//   sequencer waits with its next result until the register frees up.
module shipment_record_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  srt_req_if.sink   req_i,
  srt_rsp_if.source rsp_o
);
  import srt_pkg::*;

  req_t             req;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;
  logic             out_free;
  logic             eng_idle;
  logic             eng_done;
  logic             accept;
  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] raddr;
  logic [REC_W-1:0] rdata;

  // Pack the request payload
  always_comb begin
    req.opcode         = req_i.opcode;
    req.slot           = req_i.slot;
    req.descending     = req_i.descending;
    req.now_secs       = req_i.now_secs;
    req.rec.used       = req_i.used_in;
    req.rec.ship_state = req_i.ship_state_in;
    req.rec.track      = req_i.track_key;
    req.rec.buyer      = req_i.buyer_key;
    req.rec.seller     = req_i.seller_key;
    req.rec.product    = req_i.product_key;
    req.rec.arrival    = req_i.arrival_secs;
  end

  assign req_i.ready = eng_idle;
  assign accept      = req_i.valid && eng_idle;

  // The output register is free when empty or drained this cycle
  assign out_free = !out_valid_q || rsp_o.ready;

  srt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  srt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (req),
    .idle_o      (eng_idle),
    .out_free_i  (out_free),
    .done_o      (eng_done),
    .res_o       (res),
    .mem_wr_o    (mem_wr),
    .raddr_o     (raddr),
    .rdata_i     (rec_t'(rdata))
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.found          = out_q.found;
  assign rsp_o.where_idx      = out_q.where_idx;
  assign rsp_o.track_out      = out_q.rec.track;
  assign rsp_o.buyer_out      = out_q.rec.buyer;
  assign rsp_o.seller_out     = out_q.rec.seller;
  assign rsp_o.product_out    = out_q.rec.product;
  assign rsp_o.arrival_out    = out_q.rec.arrival;
  assign rsp_o.ship_state_out = out_q.rec.ship_state;
  assign rsp_o.used_out       = out_q.rec.used;
  assign rsp_o.any_used       = out_q.any_used;

endmodule

// ----- sv/srt_ram.sv -----
// ----------------------------------------------------------------------------
// srt_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/srt_engine.sv -----
// ----------------------------------------------------------------------------
// srt_engine - shipment record table sequencer
// Walks the record memory for write, read, search, refresh and sort.
// ----------------------------------------------------------------------------
module srt_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  srt_pkg::req_t            req_i,
  output logic                     idle_o,
  input  logic                     out_free_i,
  output logic                     done_o,
  output srt_pkg::res_t            res_o,
  output srt_pkg::mem_wr_t         mem_wr_o,
  output logic [srt_pkg::IDX_W-1:0] raddr_o,
  input  srt_pkg::rec_t            rdata_i
);
  import srt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_WRWB = 8'b00000010,
    S_RDW  = 8'b00000100,
    S_SCAN = 8'b00001000,
    S_SLD  = 8'b00010000,
    S_SRUN = 8'b00100000,
    S_SST  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_e;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   vld_rd_q;
  logic                   clr_all;
  req_t                   req_q, req_d;
  res_t                   res_q, res_d;
  rec_t                   a_q, a_d;
  rec_t                   rd_rec;
  rec_t                   wb_rec;
  logic [IDX_W-1:0]       idx_q, idx_d, j_q, j_d;
  logic                   hit;
  logic                   swap;

  // Never-written entries read as free and not sent
  always_comb begin
    rd_rec = rdata_i;
    if (!vld_rd_q) begin
      rd_rec.used       = 1'b0;
      rd_rec.ship_state = ST_NOT_SENT;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    res_d    = res_q;
    a_d      = a_q;
    idx_d    = idx_q;
    j_d      = j_q;
    clr_all  = 1'b0;
    done_o   = 1'b0;
    mem_wr_o = '0;
    raddr_o  = slot_to_idx(req_q.slot);
    hit      = 1'b0;
    swap     = 1'b0;
    wb_rec   = rd_rec;

    unique case (state_q)
      S_IDLE: begin
        raddr_o = slot_to_idx(req_i.slot);
        if (req_i.opcode inside {OP_FIND_FREE, OP_FIND_ID, OP_SORT, OP_REFRESH}) begin
          raddr_o = '0;
        end
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          idx_d = '0;
          case (req_i.opcode)
            OP_CLEAR: begin
              clr_all = 1'b1;
              cnt_d   = '0;
              state_d = S_DONE;
            end
            OP_WRITE: state_d = slot_in_range(req_i.slot) ? S_WRWB : S_DONE;
            OP_FIND_FREE, OP_FIND_ID, OP_REFRESH: state_d = S_SCAN;
            OP_SORT: state_d = S_SLD;
            OP_READ: begin
              res_d.where_idx = req_i.slot;
              state_d = slot_in_range(req_i.slot) ? S_RDW : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_WRWB: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = slot_to_idx(req_q.slot);
        mem_wr_o.data = req_q.rec;
        cnt_d   = cnt_q - CNT_W'(rd_rec.used) + CNT_W'(req_q.rec.used);
        state_d = S_DONE;
      end
      S_RDW: begin
        res_d.found = 1'b1;
        res_d.rec   = rd_rec;
        state_d     = S_DONE;
      end
      S_SCAN: begin
        raddr_o = idx_q + 1'b1;
        case (req_q.opcode)
          OP_FIND_FREE: hit = !rd_rec.used;
          OP_FIND_ID:   hit = rd_rec.used && (rd_rec.track == req_q.rec.track);
          default: begin
            // refresh: rewrite the status of occupied entries
            wb_rec.ship_state = (rd_rec.arrival <= req_q.now_secs) ?
                                ST_DELIVERED : ST_IN_TRANSIT;
            mem_wr_o.we   = rd_rec.used;
            mem_wr_o.addr = idx_q;
            mem_wr_o.data = wb_rec;
          end
        endcase
        if (hit) begin
          res_d.found     = 1'b1;
          res_d.where_idx = idx_to_slot(idx_q);
          state_d         = S_DONE;
        end else if (idx_q == LAST) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SLD: begin
        // hold entry i in a_q; stream partners j = i+1 .. last
        a_d     = rd_rec;
        j_d     = idx_q + 1'b1;
        raddr_o = idx_q + 1'b1;
        state_d = S_SRUN;
      end
      S_SRUN: begin
        raddr_o = j_q + 1'b1;
        swap = a_q.used && rd_rec.used &&
               (req_q.descending ? (a_q.track < rd_rec.track) :
                                   (a_q.track > rd_rec.track));
        if (swap) begin
          mem_wr_o.we   = 1'b1;
          mem_wr_o.addr = j_q;
          mem_wr_o.data = a_q;
          a_d           = rd_rec;
        end
        if (j_q == LAST) begin
          state_d = S_SST;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SST: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = idx_q;
        mem_wr_o.data = a_q;
        if (idx_q == LAST - 1'b1) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          raddr_o = idx_q + 1'b1;
          state_d = S_SLD;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      vld_rd_q <= valid_q[raddr_o];
      if (clr_all) begin
        valid_q <= '0;
      end else if (mem_wr_o.we) begin
        valid_q[mem_wr_o.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    a_q   <= a_d;
    idx_q <= idx_d;
    j_q   <= j_d;
  end

  always_comb begin
    res_o          = res_q;
    res_o.any_used = (cnt_q != '0);
  end

  assign idle_o = (state_q == S_IDLE);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("occupied count exceeds table depth");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_o.we && (state_q == S_SCAN || state_q == S_SRUN)) |->
    (mem_wr_o.addr != raddr_o))
    else $error("streaming write hits the entry being read");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i |-> state_q == S_IDLE)
    else $error("request taken while busy");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free_i) |=> state_q == S_IDLE)
    else $error("result not released");
`endif

endmodule
